FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the palette pixel expander.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tpx_pkg.sv
// ----------------------------------------------------------------------------
// tpx_pkg
// Types and constants shared by the palette pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tpx_pkg;

	localparam int NUM_PALETTES = 16;
	localparam int PAL_SEL_W    = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
	localparam int ENTRY_W      = 8;
	localparam int STORE_DEPTH  = NUM_PALETTES * 256;
	localparam int STORE_AW     = PAL_SEL_W + ENTRY_W;

	localparam int COLOR_W = 15;
	localparam int COORD_W = 15;
	localparam int CFG_W   = 9;
	localparam int ADDR_W  = 30;

	localparam logic [COLOR_W-1:0] MAGENTA = 15'h7C1F;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// input command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic CFG_CELLS_ACROSS = 1'b0;
	localparam logic CFG_CELLS_DOWN   = 1'b1;

	typedef struct packed {
		logic                is_pixel;
		logic                pal_ok;
		logic                pix_zero;
		logic [STORE_AW-1:0] store_addr;
		logic [COLOR_W-1:0]  color;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
	} op_t;

	// queue status toward its producer and consumer
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tpx_if.sv
// ----------------------------------------------------------------------------
// tpx_in_if / tpx_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpx_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [3:0] palette_num;
	logic [7:0] entry_index;
	logic [14:0] color_word;
	logic [8:0] cell_col;
	logic [8:0] cell_row;
	logic [11:0] pixel_offset;
	logic [7:0] pixel_value;

	modport source (output valid, cmd, palette_num, entry_index, color_word, cell_col,
		cell_row, pixel_offset, pixel_value, input ready);
	modport sink (input valid, cmd, palette_num, entry_index, color_word, cell_col,
		cell_row, pixel_offset, pixel_value, output ready);
endinterface

interface tpx_out_if;
	logic        valid;
	logic        ready;
	logic [29:0] pixel_address;
	logic [7:0]  blue_out;
	logic [7:0]  green_out;
	logic [7:0]  red_out;
	logic [7:0]  alpha_out;

	modport source (output valid, pixel_address, blue_out, green_out, red_out, alpha_out,
		input ready);
	modport sink (input valid, pixel_address, blue_out, green_out, red_out, alpha_out,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/tiled_palette_pixel_expander_top.sv
// ----------------------------------------------------------------------------
// tiled_palette_pixel_expander_top
// Tiled 8x8 indexed BGR555 palette to RGBA pixel expander.
// ----------------------------------------------------------------------------
// Takes one word per clock while the queue is not full, load or pixel alike. A load writes one entry of
// the 16 x 256 BGR555 palette store and gives no result; a pixel is turned
// from its cell/tile offset into a row-major image address and gets its
// palette color expanded to 8-bit channels plus alpha. Pixels at or past
// width*height are dropped. A pixel's result goes from its queue entry to the
// store read stage and then to the output register. The single port of the
// palette store, shared by loads and pixel reads, sets the rate of one word per
// clock while the output is not stalled. A four-word queue parts the input
// side from the output register, so each side may stall on its own.
// Configuration must be written only while the block is idle.
`default_nettype none

module tiled_palette_pixel_expander_top (
	input  logic                      clk,
	input  logic                      arst_n,
	tpx_in_if.sink                    req,
	tpx_out_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tpx_pkg::CFG_W-1:0] cfg_data
);

	logic [tpx_pkg::CFG_W-1:0] cells_across_q;
	logic [tpx_pkg::CFG_W-1:0] cells_down_q;

	logic             push;
	logic             pop;
	tpx_pkg::op_t     push_op;
	tpx_pkg::op_t     head_op;
	tpx_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_across_q <= tpx_pkg::CFG_W'(1);
			cells_down_q   <= tpx_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tpx_pkg::CFG_CELLS_ACROSS: cells_across_q <= cfg_data;
				tpx_pkg::CFG_CELLS_DOWN:   cells_down_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	tpx_front u_front (
		.req     (req),
		.q_stat  (q_stat),
		.push    (push),
		.push_op (push_op)
	);

	tpx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.q_stat  (q_stat)
	);

	tpx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head_op      (head_op),
		.pop          (pop),
		.cells_across (cells_across_q),
		.cells_down   (cells_down_q),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire

FILE: rtl/tpx_front.sv
// ----------------------------------------------------------------------------
// tpx_front
// Accepts input words, classifies load vs pixel and un-swizzles the tile
// offset into image row/column before queuing.
// ----------------------------------------------------------------------------
`default_nettype none

module tpx_front (
	tpx_in_if.sink         req,
	input  tpx_pkg::q_stat_t q_stat,
	output logic           push,
	output tpx_pkg::op_t   push_op
);

	logic [7:0] idx;

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;

	// loads address by entry_index, pixels by their palette index
	assign idx = (req.cmd == tpx_pkg::CMD_PIXEL) ? req.pixel_value : req.entry_index;

	always_comb begin
		push_op.is_pixel   = (req.cmd == tpx_pkg::CMD_PIXEL);
		push_op.pal_ok     = (32'(req.palette_num) < tpx_pkg::NUM_PALETTES);
		push_op.pix_zero   = (req.pixel_value == 8'd0);
		push_op.store_addr = {tpx_pkg::PAL_SEL_W'(req.palette_num), idx};
		push_op.color      = req.color_word;
		// offset = ty:tx:y:x, three bits each
		push_op.row        = {req.cell_row, req.pixel_offset[11:9], req.pixel_offset[5:3]};
		push_op.col        = {req.cell_col, req.pixel_offset[8:6], req.pixel_offset[2:0]};
	end

endmodule

`default_nettype wire

FILE: rtl/tpx_queue.sv
// ----------------------------------------------------------------------------
// tpx_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tpx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tpx_pkg::op_t     push_op,
	input  logic             pop,
	output tpx_pkg::op_t     head_op,
	output tpx_pkg::q_stat_t q_stat
);

	tpx_pkg::op_t                entries_q [tpx_pkg::QDEPTH];
	logic [tpx_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [tpx_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [tpx_pkg::QCNT_W-1:0]  count_q;

	assign head_op      = entries_q[rd_ptr_q];
	assign q_stat.full  = (count_q == tpx_pkg::QCNT_W'(tpx_pkg::QDEPTH));
	assign q_stat.avail = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_op;
	end

	`TPX_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !q_stat.full, "push into full queue")
	`TPX_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, q_stat.avail, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/tpx_back.sv
// ----------------------------------------------------------------------------
// tpx_back
// Executes queued operations: palette store write or read, address multiply,
// bound check and color expansion into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tpx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpx_pkg::q_stat_t            q_stat,
	input  tpx_pkg::op_t                head_op,
	output logic                        pop,
	input  logic [tpx_pkg::CFG_W-1:0]   cells_across,
	input  logic [tpx_pkg::CFG_W-1:0]   cells_down,
	tpx_out_if.source                   rsp
);

	logic [tpx_pkg::COLOR_W-1:0] store_mem [tpx_pkg::STORE_DEPTH];

	logic                               adv;
	logic                               valid_s1;
	logic                               pixel_s1;
	logic                               pal_ok_s1;
	logic                               pix_zero_s1;
	logic [tpx_pkg::COLOR_W-1:0]        rdata_s1;
	logic [tpx_pkg::COORD_W+tpx_pkg::CFG_W-1:0] prod_s1;
	logic [2*tpx_pkg::CFG_W-1:0]        area_s1;
	logic [tpx_pkg::COORD_W-1:0]        col_s1;

	logic [tpx_pkg::ADDR_W:0]           addr_full;
	logic [tpx_pkg::ADDR_W:0]           bound;
	logic                               in_bounds;
	logic [tpx_pkg::COLOR_W-1:0]        color;

	logic                               out_valid_q;
	logic [tpx_pkg::ADDR_W-1:0]         addr_q;
	logic [7:0]                         blue_q;
	logic [7:0]                         green_q;
	logic [7:0]                         red_q;
	logic [7:0]                         alpha_q;

	assign adv = !out_valid_q || rsp.ready;
	assign pop = q_stat.avail && adv;

	// single store port: one write or one read per popped word
	always_ff @(posedge clk) begin
		if (pop) begin
			if (!head_op.is_pixel) begin
				if (head_op.pal_ok)
					store_mem[head_op.store_addr] <= head_op.color;
			end else begin
				rdata_s1 <= store_mem[head_op.store_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pal_ok_s1   <= head_op.pal_ok;
			pix_zero_s1 <= head_op.pix_zero;
			prod_s1     <= (tpx_pkg::COORD_W+tpx_pkg::CFG_W)'(head_op.row)
				* (tpx_pkg::COORD_W+tpx_pkg::CFG_W)'(cells_across);
			area_s1     <= (2*tpx_pkg::CFG_W)'(cells_across)
				* (2*tpx_pkg::CFG_W)'(cells_down);
			col_s1      <= head_op.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pixel_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			pixel_s1 <= head_op.is_pixel;
		end
	end

	// addr = row * width + col, width = cells_across * 64
	assign addr_full = {1'b0, prod_s1, 6'b0} + (tpx_pkg::ADDR_W+1)'(col_s1);
	assign bound     = {1'b0, area_s1, 12'b0};
	assign in_bounds = addr_full < bound;
	assign color     = pal_ok_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s1 && pixel_s1 && in_bounds;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_q  <= addr_full[tpx_pkg::ADDR_W-1:0];
			blue_q  <= {color[14:10], 3'b0};
			green_q <= {color[9:5], 3'b0};
			red_q   <= {color[4:0], 3'b0};
			// index zero with magenta at entry zero is transparent
			alpha_q <= (pix_zero_s1 && color == tpx_pkg::MAGENTA) ? 8'h00 : 8'hFF;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.pixel_address = addr_q;
	assign rsp.blue_out      = blue_q;
	assign rsp.green_out     = green_q;
	assign rsp.red_out       = red_q;
	assign rsp.alpha_out     = alpha_q;

	`TPX_ASSERT_IMP(a_out_from_pixel, clk, arst_n, out_valid_q && !$past(out_valid_q),
		$past(valid_s1 && pixel_s1), "result word without a pixel in stage one")
	`TPX_ASSERT_NXT(a_stall_hold, clk, arst_n, !adv && valid_s1,
		valid_s1 && $stable(rdata_s1), "stage one changed during stall")

endmodule

`default_nettype wire
